FILE: hdl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package rhc_pkg;

    localparam int CHANNEL_BITS    = 8;
    localparam int HUE_BITS        = 16;
    // Hue numerator and divisor are below 6 * 2^CHANNEL_BITS.
    localparam int NUM_BITS        = CHANNEL_BITS + 3;
    // Quotient bits resolved by each divider stage.
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STEPS       = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
    localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [HUE_BITS-1:0]     hue_t;
    typedef logic [NUM_BITS-1:0]     num_t;

    typedef struct packed {
        chan_t red_in;
        chan_t green_in;
        chan_t blue_in;
    } pixel_t;

    typedef struct packed {
        hue_t  hue_out;
        chan_t sat_out;
        chan_t val_out;
    } hsv_t;

    // State of both long divisions for one pixel as it moves down the divider.
    typedef struct packed {
        num_t  hue_rem;
        num_t  hue_div;
        hue_t  hue_q;
        chan_t sat_rem;
        chan_t sat_low;
        chan_t sat_q;
        chan_t val;
        logic  gray;
    } div_lane_t;

endpackage

`default_nettype wire

FILE: hdl/rgb_to_hsv_converter.sv
// An accepted input word reaches m_data as its result word through two front stages,
// DIV_STAGES = 8 divider stages of two quotient bits each, and one output register.
// Throughput: one word per cycle while the output skid entry is empty.
// s_ready comes from a register: it drops only while the output skid buffer is full.
// Reset (aresetn low, synchronous) clears all valid flags; data registers keep junk.
// Top level of the RGB to HSV converter; depends on rhc_pkg and rhc_divider.
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rhc_pkg::pixel_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rhc_pkg::hsv_t      m_data
);

    // Which color sector the hue numerator comes from. Ties go to blue, then green.
    typedef enum logic [1:0] {
        SECT_RED_UP,    // red is max and green >= blue
        SECT_RED_DOWN,  // red is max and blue > green, wraps by a full turn
        SECT_GREEN,
        SECT_BLUE
    } hue_sect_t;

    typedef struct packed {
        rhc_pkg::chan_t red;
        rhc_pkg::chan_t green;
        rhc_pkg::chan_t blue;
        rhc_pkg::chan_t hi;
        rhc_pkg::chan_t lo;
        hue_sect_t      sect;
    } front_t;

    // The whole pipeline moves together; it stops only when the skid buffer is full.
    logic enable;

    // Stage A: max, min and sector of the incoming pixel.
    front_t a_next;
    front_t a_reg;
    logic   a_vld_reg;

    // Stage B: spread, hue numerator and divisor, saturation dividend.
    rhc_pkg::div_lane_t b_next;
    rhc_pkg::div_lane_t b_reg;
    logic               b_vld_reg;

    rhc_pkg::div_lane_t div_lane;
    logic               div_vld;
    rhc_pkg::hsv_t      result;

    // Output register plus one skid entry.
    rhc_pkg::hsv_t out_reg;
    logic          out_vld_reg;
    rhc_pkg::hsv_t skid_reg;
    logic          skid_vld_reg;

    assign enable  = !skid_vld_reg;
    assign s_ready = enable;

    always_comb begin
        logic blue_top;
        logic green_top;
        rhc_pkg::chan_t r;
        rhc_pkg::chan_t g;
        rhc_pkg::chan_t b;
        r = s_data.red_in;
        g = s_data.green_in;
        b = s_data.blue_in;
        blue_top  = (b >= r) && (b >= g);
        green_top = (g >= r) && (g >= b);
        a_next.red   = r;
        a_next.green = g;
        a_next.blue  = b;
        a_next.hi    = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
        a_next.lo    = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
        if (blue_top) begin
            a_next.sect = SECT_BLUE;
        end else if (green_top) begin
            a_next.sect = SECT_GREEN;
        end else if (g >= b) begin
            a_next.sect = SECT_RED_UP;
        end else begin
            a_next.sect = SECT_RED_DOWN;
        end
    end

    always_comb begin
        rhc_pkg::chan_t d;
        rhc_pkg::num_t  d_w;
        rhc_pkg::num_t  r_w;
        rhc_pkg::num_t  g_w;
        rhc_pkg::num_t  b_w;
        rhc_pkg::num_t  num;
        logic [2*rhc_pkg::CHANNEL_BITS-1:0] sat_num;
        d   = a_reg.hi - a_reg.lo;
        d_w = rhc_pkg::NUM_BITS'(d);
        r_w = rhc_pkg::NUM_BITS'(a_reg.red);
        g_w = rhc_pkg::NUM_BITS'(a_reg.green);
        b_w = rhc_pkg::NUM_BITS'(a_reg.blue);
        // All sums stay below six times the spread, so modular width is enough.
        unique case (a_reg.sect)
            SECT_BLUE:     num = (d_w << 2) + r_w - g_w;
            SECT_GREEN:    num = (d_w << 1) + b_w - r_w;
            SECT_RED_UP:   num = g_w - b_w;
            SECT_RED_DOWN: num = (d_w << 2) + (d_w << 1) + g_w - b_w;
            default:       num = '0;
        endcase
        // Full scale times spread, as spread shifted up minus spread.
        sat_num = {d, {rhc_pkg::CHANNEL_BITS{1'b0}}}
                  - (2*rhc_pkg::CHANNEL_BITS)'(d);
        b_next.hue_rem = num;
        b_next.hue_div = (d_w << 2) + (d_w << 1);
        b_next.hue_q   = '0;
        // The upper half is below max, so it can seed the remainder directly.
        b_next.sat_rem = sat_num[2*rhc_pkg::CHANNEL_BITS-1:rhc_pkg::CHANNEL_BITS];
        b_next.sat_low = sat_num[rhc_pkg::CHANNEL_BITS-1:0];
        b_next.sat_q   = '0;
        b_next.val     = a_reg.hi;
        b_next.gray    = (d == '0);
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (enable) begin
            a_vld_reg <= s_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    rhc_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enable    (enable),
        .in_valid  (b_vld_reg),
        .in_lane   (b_reg),
        .out_valid (div_vld),
        .out_lane  (div_lane)
    );

    // A gray pixel divides by zero and a black pixel by a zero max; both are forced to 0.
    always_comb begin
        result.hue_out = div_lane.gray ? '0 : div_lane.hue_q;
        result.sat_out = (div_lane.val == '0) ? '0 : div_lane.sat_q;
        result.val_out = div_lane.val;
    end

    // When the output word is stalled, a word leaving the divider parks in the skid
    // entry, and the pipeline stops on the next cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg <= div_vld;
        end else if (div_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_reg <= result;
        end else begin
            skid_reg <= result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // A parked word always has a word in front of it.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry full while output register empty");

    // Zero saturation means a gray pixel, which has zero hue.
    a_gray_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.sat_out == '0)) |-> (m_data.hue_out == '0))
        else $error("nonzero hue on a pixel with zero saturation");

    // A black pixel has zero saturation.
    a_black_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.val_out == '0)) |-> (m_data.sat_out == '0))
        else $error("nonzero saturation on a black pixel");

    // Saturation can only be full scale when min is zero, so the value is never zero then.
    a_full_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.sat_out == '1)) |-> (m_data.val_out != '0))
        else $error("full saturation reported with zero value");
`endif

endmodule

`default_nettype wire

FILE: hdl/rhc_divider.sv
// Pipelined restoring divider for hue and saturation, a fixed number of
// quotient bits per stage. Depends on rhc_pkg.
`default_nettype none

module rhc_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              enable,
    input  wire logic              in_valid,
    input  wire rhc_pkg::div_lane_t in_lane,
    output logic                   out_valid,
    output rhc_pkg::div_lane_t     out_lane
);

    logic [rhc_pkg::DIV_STAGES-1:0] vld_reg;
    rhc_pkg::div_lane_t             lane_reg [rhc_pkg::DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < rhc_pkg::DIV_STAGES; k++) begin : g_stage
            rhc_pkg::div_lane_t lane_cur;
            rhc_pkg::div_lane_t lane_next;

            if (k == 0) begin : g_first
                assign lane_cur = in_lane;
            end else begin : g_rest
                assign lane_cur = lane_reg[k-1];
            end

            always_comb begin
                logic [rhc_pkg::NUM_BITS:0]     hue_trial;
                logic [rhc_pkg::CHANNEL_BITS:0] sat_trial;
                lane_next = lane_cur;
                hue_trial = '0;
                sat_trial = '0;
                for (int j = 0; j < rhc_pkg::STEPS_PER_STAGE; j++) begin
                    // Hue: the remainder starts at the numerator and zeros shift in.
                    if (k * rhc_pkg::STEPS_PER_STAGE + j < rhc_pkg::HUE_BITS) begin
                        hue_trial = {lane_next.hue_rem, 1'b0};
                        if (hue_trial >= {1'b0, lane_next.hue_div}) begin
                            lane_next.hue_rem = rhc_pkg::NUM_BITS'(
                                hue_trial - {1'b0, lane_next.hue_div});
                            lane_next.hue_q = {lane_next.hue_q[rhc_pkg::HUE_BITS-2:0], 1'b1};
                        end else begin
                            lane_next.hue_rem = hue_trial[rhc_pkg::NUM_BITS-1:0];
                            lane_next.hue_q = {lane_next.hue_q[rhc_pkg::HUE_BITS-2:0], 1'b0};
                        end
                    end
                    // Saturation: the low half of the dividend shifts into the remainder.
                    if (k * rhc_pkg::STEPS_PER_STAGE + j < rhc_pkg::CHANNEL_BITS) begin
                        sat_trial = {lane_next.sat_rem,
                                     lane_next.sat_low[rhc_pkg::CHANNEL_BITS-1]};
                        lane_next.sat_low = {lane_next.sat_low[rhc_pkg::CHANNEL_BITS-2:0],
                                             1'b0};
                        if (sat_trial >= {1'b0, lane_next.val}) begin
                            lane_next.sat_rem = rhc_pkg::CHANNEL_BITS'(
                                sat_trial - {1'b0, lane_next.val});
                            lane_next.sat_q = {lane_next.sat_q[rhc_pkg::CHANNEL_BITS-2:0],
                                               1'b1};
                        end else begin
                            lane_next.sat_rem = sat_trial[rhc_pkg::CHANNEL_BITS-1:0];
                            lane_next.sat_q = {lane_next.sat_q[rhc_pkg::CHANNEL_BITS-2:0],
                                               1'b0};
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (enable) begin
                    lane_reg[k] <= lane_next;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (enable) begin
            vld_reg <= {vld_reg[rhc_pkg::DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[rhc_pkg::DIV_STAGES-1];
    assign out_lane  = lane_reg[rhc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire
